FILE: rtl/pstu_pkg.sv
// Package for the particle steering update block: shared types, register
// indexes and default constants. No dependencies.
package pstu_pkg;

  localparam int SCREEN_WIDTH_DEF  = 1024;
  localparam int SCREEN_HEIGHT_DEF = 1024;

  localparam logic signed [33:0] POS_MAX = 34'sd67108863;
  localparam logic [16:0]        Q_ONE   = 17'd65536;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_MAX_SPEED       = 3'd0,
    REG_STEER_STRENGTH  = 3'd1,
    REG_WANDER_STRENGTH = 3'd2,
    REG_TIME_STEP       = 3'd3,
    REG_TARGET_X        = 3'd4,
    REG_TARGET_Y        = 3'd5,
    REG_WANDER_MODE     = 3'd6
  } reg_idx_t;

  // Particle fields carried along the whole pipe
  typedef struct packed {
    logic [25:0]        px;
    logic [25:0]        py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               last;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
  } side_t;

  // Direction normalize operands
  typedef struct packed {
    logic [25:0] ax;
    logic [25:0] ay;
    logic        sgnx;
    logic        sgny;
  } nrm_t;

  // Steering force magnitudes after the range shift
  typedef struct packed {
    logic [30:0] msx;
    logic [30:0] msy;
    logic        sgnx;
    logic        sgny;
    logic        k0;
  } frc_t;

  // Force scaling control for the second divider
  typedef struct packed {
    logic [30:0] msx;
    logic [30:0] msy;
    logic        sgnx;
    logic        sgny;
    logic        byp;
    logic        zero;
  } scl_t;

endpackage

FILE: rtl/particle_steering_update.sv
// Particle steering update (seek / wander), Q16.16 fixed point, deep pipeline.
// Uses pstu_pkg for types, register indexes and defaults.
//
//  channel | ports                         | direction | handshake
//  --------+-------------------------------+-----------+---------------------------
//  input   | in_valid/in_stall, in_*       | in        | accept: valid & !stall
//  output  | out_valid/out_stall, out_*    | out       | accept: valid & !stall
//  config  | psel/penable/pwrite/paddr/... | in        | APB read/write, pready tied high
//
// One transaction enters per cycle while the output is not stalled. Most of
// the pipe depth comes from the two bit-per-stage square roots (27 and 32
// stages) and the two bit-per-stage dividers (17 and 20 stages).
// A stalled valid output freezes the whole pipe (all stages share one enable), so
// nothing is dropped or repeated; in_stall is high exactly while that happens.
// Reset clears the stage valid bits and loads the register defaults.
module particle_steering_update #(
  parameter int SCREEN_WIDTH  = pstu_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pstu_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [25:0]        in_pos_x,
  input  logic [25:0]        in_pos_y,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [17:0] in_dir_x,
  input  logic signed [17:0] in_dir_y,
  input  logic [15:0]        in_rand_x,
  input  logic [15:0]        in_rand_y,
  input  logic               in_last_particle,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [25:0]        out_new_pos_x,
  output logic [25:0]        out_new_pos_y,
  output logic signed [31:0] out_new_vel_x,
  output logic signed [31:0] out_new_vel_y,
  output logic signed [17:0] out_new_dir_x,
  output logic signed [17:0] out_new_dir_y,
  output logic               out_last_out,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pstu_pkg::*;

  localparam logic signed [33:0] EXT_X = 34'(SCREEN_WIDTH - 1) << 16;
  localparam logic signed [33:0] EXT_Y = 34'(SCREEN_HEIGHT - 1) << 16;
  localparam logic signed [33:0] TOP_X = (EXT_X < POS_MAX) ? EXT_X : POS_MAX;
  localparam logic signed [33:0] TOP_Y = (EXT_Y < POS_MAX) ? EXT_Y : POS_MAX;

  localparam int SQ1 = 27;  // root bits, direction length
  localparam int DV1 = 17;  // quotient bits, direction normalize
  localparam int SQ2 = 32;  // root bits, force length
  localparam int DV2 = 20;  // quotient bits, force scaling

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [19:0] max_speed_r, steer_strength_r, wander_strength_r;
  logic [16:0] time_step_r;
  logic [25:0] target_x_r, target_y_r;
  logic        wander_mode_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r       <= 20'd65536;
      steer_strength_r  <= 20'd65536;
      wander_strength_r <= 20'd65536;
      time_step_r       <= 17'd655;
      target_x_r        <= '0;
      target_y_r        <= '0;
      wander_mode_r     <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_MAX_SPEED:       max_speed_r       <= pwdata[19:0];
        REG_STEER_STRENGTH:  steer_strength_r  <= pwdata[19:0];
        REG_WANDER_STRENGTH: wander_strength_r <= pwdata[19:0];
        REG_TIME_STEP:       time_step_r       <= pwdata[16:0];
        REG_TARGET_X:        target_x_r        <= pwdata[25:0];
        REG_TARGET_Y:        target_y_r        <= pwdata[25:0];
        REG_WANDER_MODE:     wander_mode_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_MAX_SPEED:       prdata = 32'(max_speed_r);
      REG_STEER_STRENGTH:  prdata = 32'(steer_strength_r);
      REG_WANDER_STRENGTH: prdata = 32'(wander_strength_r);
      REG_TIME_STEP:       prdata = 32'(time_step_r);
      REG_TARGET_X:        prdata = 32'(target_x_r);
      REG_TARGET_Y:        prdata = 32'(target_y_r);
      REG_WANDER_MODE:     prdata = 32'(wander_mode_r);
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Global pipe enable: everything moves unless a finished result is held.
  // ---------------------------------------------------------------------------
  logic en, in_acc, out_v_r;

  assign en       = !out_v_r || !out_stall;
  assign in_stall = !en;
  assign in_acc   = in_valid && en;

  // ---------------------------------------------------------------------------
  // Stage 1: wander offset or seek difference
  // ---------------------------------------------------------------------------
  logic signed [16:0] offx, offy;
  logic signed [37:0] wpx, wpy;
  logic signed [27:0] ux_nxt, uy_nxt;
  logic signed [27:0] ux_r, uy_r;
  side_t              side1_r, side_in;
  logic               v1_r;

  always_comb begin
    offx = $signed({1'b0, in_rand_x}) - 17'sd32768;
    offy = $signed({1'b0, in_rand_y}) - 17'sd32768;
    wpx  = offx * $signed({1'b0, wander_strength_r});
    wpy  = offy * $signed({1'b0, wander_strength_r});
    if (wander_mode_r) begin
      ux_nxt = 28'(in_dir_x) + 28'(wpx >>> 16);
      uy_nxt = 28'(in_dir_y) + 28'(wpy >>> 16);
    end else begin
      ux_nxt = $signed({2'b00, target_x_r}) - $signed({2'b00, in_pos_x});
      uy_nxt = $signed({2'b00, target_y_r}) - $signed({2'b00, in_pos_y});
    end
    side_in.px   = in_pos_x;
    side_in.py   = in_pos_y;
    side_in.vx   = in_vel_x;
    side_in.vy   = in_vel_y;
    side_in.last = in_last_particle;
    side_in.nx   = '0;
    side_in.ny   = '0;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: magnitudes and squares
  // ---------------------------------------------------------------------------
  logic [25:0] ax2_nxt, ay2_nxt;
  logic [51:0] sqx_r, sqy_r;
  nrm_t        nrm2_r;
  side_t       side2_r;
  logic        v2_r;

  assign ax2_nxt = ux_r[27] ? 26'(-ux_r) : 26'(ux_r);
  assign ay2_nxt = uy_r[27] ? 26'(-uy_r) : 26'(uy_r);

  // ---------------------------------------------------------------------------
  // Square root 1: index 0 holds the radicand (stage 3), one root bit a stage
  // ---------------------------------------------------------------------------
  logic [53:0] s1_rad_r  [0:SQ1];
  logic [27:0] s1_rem_r  [0:SQ1];
  logic [26:0] s1_root_r [0:SQ1];
  nrm_t        s1_nrm_r  [0:SQ1];
  side_t       s1_side_r [0:SQ1];
  logic        s1_v_r    [0:SQ1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      s1_v_r[0] <= 1'b0;
    end else if (en) begin
      v1_r      <= in_acc;
      v2_r      <= v1_r;
      s1_v_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r           <= ux_nxt;
      uy_r           <= uy_nxt;
      side1_r        <= side_in;
      sqx_r          <= ax2_nxt * ax2_nxt;
      sqy_r          <= ay2_nxt * ay2_nxt;
      nrm2_r.ax      <= ax2_nxt;
      nrm2_r.ay      <= ay2_nxt;
      nrm2_r.sgnx    <= ux_r[27];
      nrm2_r.sgny    <= uy_r[27];
      side2_r        <= side1_r;
      s1_rad_r[0]    <= 54'(sqx_r) + 54'(sqy_r);
      s1_rem_r[0]    <= '0;
      s1_root_r[0]   <= '0;
      s1_nrm_r[0]    <= nrm2_r;
      s1_side_r[0]   <= side2_r;
    end
  end

  for (genvar k = 1; k <= SQ1; k++) begin : g_sq1
    logic [29:0] tmp, trial;
    logic        take;
    always_comb begin
      tmp   = {s1_rem_r[k-1], s1_rad_r[k-1][53:52]};
      trial = {1'b0, s1_root_r[k-1], 2'b01};
      take  = (tmp >= trial);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) s1_v_r[k] <= 1'b0;
      else if (en) s1_v_r[k] <= s1_v_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s1_rad_r[k]  <= s1_rad_r[k-1] << 2;
        s1_rem_r[k]  <= take ? 28'(tmp - trial) : 28'(tmp);
        s1_root_r[k] <= {s1_root_r[k-1][25:0], take};
        s1_nrm_r[k]  <= s1_nrm_r[k-1];
        s1_side_r[k] <= s1_side_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Divider 1: (a << 16) / len for x and y; index 0 loads the operands.
  // dq shifts dividend bits out at the top and quotient bits in at the bottom.
  // ---------------------------------------------------------------------------
  logic [26:0] d1_len_r  [0:DV1];
  logic [26:0] d1_remx_r [0:DV1];
  logic [26:0] d1_remy_r [0:DV1];
  logic [16:0] d1_dqx_r  [0:DV1];
  logic [16:0] d1_dqy_r  [0:DV1];
  logic        d1_sgnx_r [0:DV1];
  logic        d1_sgny_r [0:DV1];
  side_t       d1_side_r [0:DV1];
  logic        d1_v_r    [0:DV1];

  always_ff @(posedge clk) begin
    if (!rst_n) d1_v_r[0] <= 1'b0;
    else if (en) d1_v_r[0] <= s1_v_r[SQ1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_len_r[0]  <= s1_root_r[SQ1];
      d1_remx_r[0] <= 27'(s1_nrm_r[SQ1].ax[25:1]);
      d1_remy_r[0] <= 27'(s1_nrm_r[SQ1].ay[25:1]);
      d1_dqx_r[0]  <= {s1_nrm_r[SQ1].ax[0], 16'h0000};
      d1_dqy_r[0]  <= {s1_nrm_r[SQ1].ay[0], 16'h0000};
      d1_sgnx_r[0] <= s1_nrm_r[SQ1].sgnx;
      d1_sgny_r[0] <= s1_nrm_r[SQ1].sgny;
      d1_side_r[0] <= s1_side_r[SQ1];
    end
  end

  for (genvar k = 1; k <= DV1; k++) begin : g_dv1
    logic [27:0] tx, ty, dl;
    logic        bx, by;
    always_comb begin
      tx = {d1_remx_r[k-1], d1_dqx_r[k-1][16]};
      ty = {d1_remy_r[k-1], d1_dqy_r[k-1][16]};
      dl = {1'b0, d1_len_r[k-1]};
      bx = (tx >= dl);
      by = (ty >= dl);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) d1_v_r[k] <= 1'b0;
      else if (en) d1_v_r[k] <= d1_v_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d1_len_r[k]  <= d1_len_r[k-1];
        d1_remx_r[k] <= bx ? 27'(tx - dl) : 27'(tx);
        d1_remy_r[k] <= by ? 27'(ty - dl) : 27'(ty);
        d1_dqx_r[k]  <= {d1_dqx_r[k-1][15:0], bx};
        d1_dqy_r[k]  <= {d1_dqy_r[k-1][15:0], by};
        d1_sgnx_r[k] <= d1_sgnx_r[k-1];
        d1_sgny_r[k] <= d1_sgny_r[k-1];
        d1_side_r[k] <= d1_side_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage N: clamp, sign, zero length -> new direction
  // ---------------------------------------------------------------------------
  logic [16:0]        qnx, qny;
  logic signed [17:0] nx_nxt, ny_nxt;
  side_t              sideN_r;
  logic               vN_r;

  always_comb begin
    qnx = (d1_dqx_r[DV1] > Q_ONE) ? Q_ONE : d1_dqx_r[DV1];
    qny = (d1_dqy_r[DV1] > Q_ONE) ? Q_ONE : d1_dqy_r[DV1];
    if (d1_len_r[DV1] == '0) begin
      nx_nxt = '0;
      ny_nxt = '0;
    end else begin
      nx_nxt = d1_sgnx_r[DV1] ? -$signed({1'b0, qnx}) : $signed({1'b0, qnx});
      ny_nxt = d1_sgny_r[DV1] ? -$signed({1'b0, qny}) : $signed({1'b0, qny});
    end
  end

  // ---------------------------------------------------------------------------
  // Stages M1..M4: desired velocity, steering force, range shift, squares
  // ---------------------------------------------------------------------------
  logic signed [37:0] m1_px_r, m1_py_r;
  logic signed [53:0] m2_px_r, m2_py_r;
  logic signed [32:0] dsx, dsy;
  logic signed [37:0] sx3, sy3;
  logic [36:0]        magx, magy, mmax;
  logic [2:0]         ksh;
  frc_t               frc_nxt, frc3_r, frc4_r;
  logic [61:0]        m4_sqx_r, m4_sqy_r;
  side_t              side_m1_r, side_m2_r, side_m3_r, side_m4_r;
  logic               vm1_r, vm2_r, vm3_r, vm4_r;

  always_comb begin
    dsx  = 33'(m1_px_r >>> 16) - 33'(side_m1_r.vx);
    dsy  = 33'(m1_py_r >>> 16) - 33'(side_m1_r.vy);
    sx3  = 38'(m2_px_r >>> 16);
    sy3  = 38'(m2_py_r >>> 16);
    magx = sx3[37] ? 37'(-sx3) : 37'(sx3);
    magy = sy3[37] ? 37'(-sy3) : 37'(sy3);
    mmax = (magx > magy) ? magx : magy;
    ksh  = '0;
    for (int i = 0; i < 6; i++) begin
      if (mmax[31+i]) ksh = 3'(i + 1);
    end
    frc_nxt.msx  = 31'(magx >> ksh);
    frc_nxt.msy  = 31'(magy >> ksh);
    frc_nxt.sgnx = sx3[37];
    frc_nxt.sgny = sy3[37];
    frc_nxt.k0   = (ksh == '0);
  end

  // ---------------------------------------------------------------------------
  // Square root 2 on the shifted force; index 0 is stage M5
  // ---------------------------------------------------------------------------
  logic [63:0] s2_rad_r  [0:SQ2];
  logic [32:0] s2_rem_r  [0:SQ2];
  logic [31:0] s2_root_r [0:SQ2];
  frc_t        s2_frc_r  [0:SQ2];
  side_t       s2_side_r [0:SQ2];
  logic        s2_v_r    [0:SQ2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vN_r      <= 1'b0;
      vm1_r     <= 1'b0;
      vm2_r     <= 1'b0;
      vm3_r     <= 1'b0;
      vm4_r     <= 1'b0;
      s2_v_r[0] <= 1'b0;
    end else if (en) begin
      vN_r      <= d1_v_r[DV1];
      vm1_r     <= vN_r;
      vm2_r     <= vm1_r;
      vm3_r     <= vm2_r;
      vm4_r     <= vm3_r;
      s2_v_r[0] <= vm4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sideN_r      <= d1_side_r[DV1];
      sideN_r.nx   <= nx_nxt;
      sideN_r.ny   <= ny_nxt;
      m1_px_r      <= sideN_r.nx * $signed({1'b0, max_speed_r});
      m1_py_r      <= sideN_r.ny * $signed({1'b0, max_speed_r});
      side_m1_r    <= sideN_r;
      m2_px_r      <= dsx * $signed({1'b0, steer_strength_r});
      m2_py_r      <= dsy * $signed({1'b0, steer_strength_r});
      side_m2_r    <= side_m1_r;
      frc3_r       <= frc_nxt;
      side_m3_r    <= side_m2_r;
      m4_sqx_r     <= frc3_r.msx * frc3_r.msx;
      m4_sqy_r     <= frc3_r.msy * frc3_r.msy;
      frc4_r       <= frc3_r;
      side_m4_r    <= side_m3_r;
      s2_rad_r[0]  <= 64'(m4_sqx_r) + 64'(m4_sqy_r);
      s2_rem_r[0]  <= '0;
      s2_root_r[0] <= '0;
      s2_frc_r[0]  <= frc4_r;
      s2_side_r[0] <= side_m4_r;
    end
  end

  for (genvar k = 1; k <= SQ2; k++) begin : g_sq2
    logic [34:0] tmp, trial;
    logic        take;
    always_comb begin
      tmp   = {s2_rem_r[k-1], s2_rad_r[k-1][63:62]};
      trial = {1'b0, s2_root_r[k-1], 2'b01};
      take  = (tmp >= trial);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) s2_v_r[k] <= 1'b0;
      else if (en) s2_v_r[k] <= s2_v_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s2_rad_r[k]  <= s2_rad_r[k-1] << 2;
        s2_rem_r[k]  <= take ? 33'(tmp - trial) : 33'(tmp);
        s2_root_r[k] <= {s2_root_r[k-1][30:0], take};
        s2_frc_r[k]  <= s2_frc_r[k-1];
        s2_side_r[k] <= s2_side_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Divider 2: msx * steer_strength / len; index 0 forms the products.
  // Quotient fits 20 bits since msx <= len.
  // ---------------------------------------------------------------------------
  logic [50:0] pfx, pfy;
  scl_t        scl_nxt;
  logic [31:0] d2_len_r  [0:DV2];
  logic [31:0] d2_remx_r [0:DV2];
  logic [31:0] d2_remy_r [0:DV2];
  logic [19:0] d2_dqx_r  [0:DV2];
  logic [19:0] d2_dqy_r  [0:DV2];
  scl_t        d2_scl_r  [0:DV2];
  side_t       d2_side_r [0:DV2];
  logic        d2_v_r    [0:DV2];

  always_comb begin
    pfx          = s2_frc_r[SQ2].msx * steer_strength_r;
    pfy          = s2_frc_r[SQ2].msy * steer_strength_r;
    scl_nxt.msx  = s2_frc_r[SQ2].msx;
    scl_nxt.msy  = s2_frc_r[SQ2].msy;
    scl_nxt.sgnx = s2_frc_r[SQ2].sgnx;
    scl_nxt.sgny = s2_frc_r[SQ2].sgny;
    // small force passes unchanged when no range shift was needed and its length is within steer_strength
    scl_nxt.byp  = s2_frc_r[SQ2].k0 && (s2_root_r[SQ2] <= 32'(steer_strength_r));
    scl_nxt.zero = (s2_root_r[SQ2] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d2_v_r[0] <= 1'b0;
    else if (en) d2_v_r[0] <= s2_v_r[SQ2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_len_r[0]  <= s2_root_r[SQ2];
      d2_remx_r[0] <= 32'(pfx[50:20]);
      d2_remy_r[0] <= 32'(pfy[50:20]);
      d2_dqx_r[0]  <= pfx[19:0];
      d2_dqy_r[0]  <= pfy[19:0];
      d2_scl_r[0]  <= scl_nxt;
      d2_side_r[0] <= s2_side_r[SQ2];
    end
  end

  for (genvar k = 1; k <= DV2; k++) begin : g_dv2
    logic [32:0] tx, ty, dl;
    logic        bx, by;
    always_comb begin
      tx = {d2_remx_r[k-1], d2_dqx_r[k-1][19]};
      ty = {d2_remy_r[k-1], d2_dqy_r[k-1][19]};
      dl = {1'b0, d2_len_r[k-1]};
      bx = (tx >= dl);
      by = (ty >= dl);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) d2_v_r[k] <= 1'b0;
      else if (en) d2_v_r[k] <= d2_v_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d2_len_r[k]  <= d2_len_r[k-1];
        d2_remx_r[k] <= bx ? 32'(tx - dl) : 32'(tx);
        d2_remy_r[k] <= by ? 32'(ty - dl) : 32'(ty);
        d2_dqx_r[k]  <= {d2_dqx_r[k-1][18:0], bx};
        d2_dqy_r[k]  <= {d2_dqy_r[k-1][18:0], by};
        d2_scl_r[k]  <= d2_scl_r[k-1];
        d2_side_r[k] <= d2_side_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages A1..A5: force select, velocity and position integration, wrap
  // ---------------------------------------------------------------------------
  scl_t               scl_f;
  logic [19:0]        qfx, qfy;
  logic signed [20:0] accx_nxt, accy_nxt, a1_ax_r, a1_ay_r;
  logic signed [38:0] a2_px_r, a2_py_r;
  logic signed [33:0] nvx_sum, nvy_sum;
  logic signed [31:0] nvx_nxt, nvy_nxt, a3_vx_r, a3_vy_r, a4_vx_r, a4_vy_r;
  logic signed [49:0] a4_px_r, a4_py_r;
  logic signed [33:0] psx, psy;
  side_t              side_a1_r, side_a2_r, side_a3_r, side_a4_r;
  logic               va1_r, va2_r, va3_r, va4_r;
  logic [25:0]        out_px_r, out_py_r;
  logic signed [31:0] out_vx_r, out_vy_r;
  logic signed [17:0] out_dx_r, out_dy_r;
  logic               out_last_r;

  function automatic logic [25:0] wrap_f(input logic signed [33:0] p,
                                         input logic signed [33:0] ext,
                                         input logic signed [33:0] top);
    logic signed [33:0] w;
    w = p;
    if (w >= ext) w = w - ext;
    else if (w < 0) w = w + ext;
    if (w < 0) w = '0;
    if (w > top) w = top;
    return w[25:0];
  endfunction

  always_comb begin
    scl_f = d2_scl_r[DV2];
    if (scl_f.zero) begin
      qfx = '0;
      qfy = '0;
    end else if (scl_f.byp) begin
      qfx = 20'(scl_f.msx);
      qfy = 20'(scl_f.msy);
    end else begin
      qfx = d2_dqx_r[DV2];
      qfy = d2_dqy_r[DV2];
    end
    accx_nxt = scl_f.sgnx ? -$signed({1'b0, qfx}) : $signed({1'b0, qfx});
    accy_nxt = scl_f.sgny ? -$signed({1'b0, qfy}) : $signed({1'b0, qfy});

    nvx_sum = 34'(side_a2_r.vx) + 34'(a2_px_r >>> 16);
    nvy_sum = 34'(side_a2_r.vy) + 34'(a2_py_r >>> 16);
    if (nvx_sum > 34'sd2147483647)       nvx_nxt = 32'sh7FFFFFFF;
    else if (nvx_sum < -34'sd2147483648) nvx_nxt = 32'sh80000000;
    else                                 nvx_nxt = 32'(nvx_sum);
    if (nvy_sum > 34'sd2147483647)       nvy_nxt = 32'sh7FFFFFFF;
    else if (nvy_sum < -34'sd2147483648) nvy_nxt = 32'sh80000000;
    else                                 nvy_nxt = 32'(nvy_sum);

    psx = $signed({8'b0, side_a4_r.px}) + 34'(a4_px_r >>> 16);
    psy = $signed({8'b0, side_a4_r.py}) + 34'(a4_py_r >>> 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va1_r   <= 1'b0;
      va2_r   <= 1'b0;
      va3_r   <= 1'b0;
      va4_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      va1_r   <= d2_v_r[DV2];
      va2_r   <= va1_r;
      va3_r   <= va2_r;
      va4_r   <= va3_r;
      out_v_r <= va4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_ax_r    <= accx_nxt;
      a1_ay_r    <= accy_nxt;
      side_a1_r  <= d2_side_r[DV2];
      a2_px_r    <= a1_ax_r * $signed({1'b0, time_step_r});
      a2_py_r    <= a1_ay_r * $signed({1'b0, time_step_r});
      side_a2_r  <= side_a1_r;
      a3_vx_r    <= nvx_nxt;
      a3_vy_r    <= nvy_nxt;
      side_a3_r  <= side_a2_r;
      a4_px_r    <= a3_vx_r * $signed({1'b0, time_step_r});
      a4_py_r    <= a3_vy_r * $signed({1'b0, time_step_r});
      a4_vx_r    <= a3_vx_r;
      a4_vy_r    <= a3_vy_r;
      side_a4_r  <= side_a3_r;
      out_px_r   <= wrap_f(psx, EXT_X, TOP_X);
      out_py_r   <= wrap_f(psy, EXT_Y, TOP_Y);
      out_vx_r   <= a4_vx_r;
      out_vy_r   <= a4_vy_r;
      out_dx_r   <= side_a4_r.nx;
      out_dy_r   <= side_a4_r.ny;
      out_last_r <= side_a4_r.last;
    end
  end

  assign out_valid     = out_v_r;
  assign out_new_pos_x = out_px_r;
  assign out_new_pos_y = out_py_r;
  assign out_new_vel_x = out_vx_r;
  assign out_new_vel_y = out_vy_r;
  assign out_new_dir_x = out_dx_r;
  assign out_new_dir_y = out_dy_r;
  assign out_last_out  = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v1_r)
    else $error("accepted transaction did not enter the pipe");

  a_dir_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_new_dir_x <= 18'sd65536) && (out_new_dir_x >= -18'sd65536) &&
                  (out_new_dir_y <= 18'sd65536) && (out_new_dir_y >= -18'sd65536))
    else $error("direction component outside unit range");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed({8'b0, out_new_pos_x}) <= TOP_X) &&
                  ($signed({8'b0, out_new_pos_y}) <= TOP_Y))
    else $error("wrapped position above screen extent");

  a_force_bound: assert property (@(posedge clk) disable iff (!rst_n)
    va1_r |-> (a1_ax_r <= $signed({1'b0, steer_strength_r})) &&
              (a1_ax_r >= -$signed({1'b0, steer_strength_r})))
    else $error("steering force exceeds steer strength");

endmodule
